// ===== src/dwwc_pkg.sv =====
// Shared types and constants for the deep water window classifier.
// Holds the transaction payload structs, tile and result codes, and the
// controller/datapath command and status structs. No dependencies.
package dwwc_pkg;

    localparam int COORD_W = 6;
    localparam int CLASS_W = 2;
    // Wide enough for a coordinate plus the largest radius, and for an
    // extent of up to 256 tiles.
    localparam int SPAN_W  = 9;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WATER = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DEEP  = 2'd2;

    // Which value the output register takes when a query completes.
    localparam logic [1:0] RES_OTHER  = 2'd0;
    localparam logic [1:0] RES_STORED = 2'd1;
    localparam logic [1:0] RES_DEEP   = 2'd2;
    // The centre was water but the window scan found a dry cell.
    localparam logic [1:0] RES_WATER  = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [CLASS_W-1:0] tile_class;
        logic               in_ocean;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CLASS_W-1:0] result_class;
    } out_item_t;

    typedef struct packed {
        logic       latch;      // capture the accepted item's position
        logic       store;      // write the accepted tile into the grid
        logic       rd_center;  // read the queried tile
        logic       scan_clear; // restart the window counters
        logic       rd_win;     // read the next window cell
        logic       load_out;   // load the output register
        logic [1:0] res_sel;
    } dwwc_cmd_t;

    typedef struct packed {
        logic center_inside;
        logic center_wet_ocean;
        logic win_inside;
        logic cell_pend;
        logic cell_wet;
        logic issue_done;
        logic out_free;
    } dwwc_status_t;

endpackage

// ===== src/dwwc_ctrl.sv =====
// Controller state machine of the deep water window classifier.
// Sequences stores, the centre read and the window scan. Depends on dwwc_pkg.
module dwwc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_kind,
    output logic                  in_ready,
    input  dwwc_pkg::dwwc_status_t status,
    output dwwc_pkg::dwwc_cmd_t    cmd
);
    import dwwc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_reg   <= RES_OTHER;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.res_sel    = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                cmd.store = in_valid && (in_kind == KIND_WRITE);
                if (in_valid && (in_kind == KIND_QUERY)) begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER: begin
                cmd.rd_center  = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK: begin
                if (!status.center_inside) begin
                    res_next   = RES_OTHER;
                    state_next = S_OUT;
                end else if (!status.center_wet_ocean || !status.win_inside) begin
                    res_next   = RES_STORED;
                    state_next = S_OUT;
                end else begin
                    cmd.rd_win = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued back to back; each cycle checks the cell read
                // in the previous one and stops at the first dry cell.
                if (status.cell_pend && !status.cell_wet) begin
                    res_next   = RES_WATER;
                    state_next = S_OUT;
                end else if (status.cell_pend && status.issue_done) begin
                    res_next   = RES_DEEP;
                    state_next = S_OUT;
                end else begin
                    cmd.rd_win = !status.issue_done;
                end
            end
            S_OUT: begin
                cmd.load_out = status.out_free;
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dwwc_datapath.sv =====
// Datapath of the deep water window classifier: tile memory, item registers,
// window counters and bounds, and the output register. Depends on dwwc_pkg.
module dwwc_datapath #(
    parameter int GRID_SIDE  = 64,
    parameter int MAX_RADIUS = 7
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dwwc_pkg::in_item_t     in_item,
    input  logic [2:0]             radius,
    input  logic [6:0]             grid_extent,
    input  dwwc_pkg::dwwc_cmd_t    cmd,
    output dwwc_pkg::dwwc_status_t status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output dwwc_pkg::out_item_t    out_item
);
    import dwwc_pkg::*;

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 1);

    // Each word holds the class in its low bits and the ocean flag on top.
    logic [CLASS_W:0] mem [CELLS];
    logic [CLASS_W:0] rdata_reg;

    logic [COORD_W-1:0] x_reg, y_reg;
    logic [CNT_W-1:0]   ix_reg, ix_next, iy_reg, iy_next;
    logic               pend_reg, done_reg, done_next;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [2:0]         r_eff;
    logic [SPAN_W-1:0]  ext, cx, cy, rr, wx, wy, in_x, in_y;
    logic [CNT_W-1:0]   last_idx;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic               in_inside, out_free;
    logic [CLASS_W-1:0] wr_class, res_class;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SPAN_W-1:0] row,
                                                    input logic [SPAN_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * GRID_SIDE + int'(col));
    endfunction

    assign r_eff    = (int'(radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius;
    assign ext      = (int'(grid_extent) > GRID_SIDE) ? SPAN_W'(GRID_SIDE)
                                                      : SPAN_W'(grid_extent);
    assign cx       = SPAN_W'(x_reg);
    assign cy       = SPAN_W'(y_reg);
    assign rr       = SPAN_W'(r_eff);
    assign last_idx = CNT_W'({r_eff, 1'b0});
    assign wx       = cx - rr + SPAN_W'(ix_reg);
    assign wy       = cy - rr + SPAN_W'(iy_reg);

    assign in_x      = SPAN_W'(in_item.pos_x);
    assign in_y      = SPAN_W'(in_item.pos_y);
    assign in_inside = (int'(in_x) < GRID_SIDE) && (int'(in_y) < GRID_SIDE);
    assign wr_class  = ((in_item.tile_class == CLASS_WATER) ||
                        (in_item.tile_class == CLASS_DEEP)) ? in_item.tile_class
                                                            : CLASS_OTHER;
    assign wr_addr   = cell_addr(in_y, in_x);
    assign rd_addr   = cmd.rd_center ? cell_addr(cy, cx) : cell_addr(wy, wx);

    always_ff @(posedge aclk) begin
        if (cmd.store && in_inside) begin
            mem[wr_addr] <= {in_item.in_ocean, wr_class};
        end
        if (cmd.rd_center || cmd.rd_win) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.latch) begin
            x_reg <= in_item.pos_x;
            y_reg <= in_item.pos_y;
        end
    end

    // Window counters walk the cells row by row.
    always_comb begin
        ix_next   = ix_reg;
        iy_next   = iy_reg;
        done_next = done_reg;
        if (cmd.scan_clear) begin
            ix_next   = '0;
            iy_next   = '0;
            done_next = 1'b0;
        end else if (cmd.rd_win) begin
            if (ix_reg == last_idx) begin
                ix_next = '0;
                iy_next = iy_reg + CNT_W'(1);
                if (iy_reg == last_idx) begin
                    done_next = 1'b1;
                end
            end else begin
                ix_next = ix_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ix_reg   <= '0;
            iy_reg   <= '0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            ix_reg   <= ix_next;
            iy_reg   <= iy_next;
            done_reg <= done_next;
            pend_reg <= cmd.rd_win;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        unique case (cmd.res_sel)
            RES_OTHER:  res_class = CLASS_OTHER;
            RES_STORED: res_class = rdata_reg[CLASS_W-1:0];
            RES_DEEP:   res_class = CLASS_DEEP;
            RES_WATER:  res_class = CLASS_WATER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.out_x        <= x_reg;
            out_reg.out_y        <= y_reg;
            out_reg.result_class <= res_class;
        end
    end

    assign status.center_inside    = (int'(cx) < GRID_SIDE) && (int'(cy) < GRID_SIDE);
    assign status.center_wet_ocean = (rdata_reg[CLASS_W-1:0] == CLASS_WATER)
                                     && rdata_reg[CLASS_W];
    // The whole window must fit in the extent; an extent of zero never fits.
    assign status.win_inside = (cx >= rr) && (cy >= rr)
                               && ((cx + rr) < ext) && ((cy + rr) < ext);
    assign status.cell_pend  = pend_reg;
    assign status.cell_wet   = (rdata_reg[CLASS_W-1:0] == CLASS_WATER)
                               || (rdata_reg[CLASS_W-1:0] == CLASS_DEEP);
    assign status.issue_done = done_reg;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== src/deep_water_window_classifier.sv =====
// Top level of the deep water window classifier: configuration registers and
// the controller and datapath. Depends on dwwc_pkg, dwwc_ctrl, dwwc_datapath.
//
// Usage: each input transaction on s_ (valid/ready) is either a tile write or a
// query. A write stores the class and ocean flag of one tile and gives no result;
// the block stays idle and ready for the next item after it. A query returns one
// result transaction on m_ with the tile's position and its class after the
// deepwater rule: a water tile in an ocean region reads as deepwater when the
// whole square window of the configured radius lies inside the used extent and is
// water or deepwater. A query reads the centre tile, then the window cells
// through the single read port of the tile memory, which reads one window cell per
// cycle; a query that fails early, on the centre tile, the window bounds or a dry
// cell, stops before the whole window is read. One item is in work at a time, and
// the next is taken once the result sits in the output register. The radius and
// grid_extent registers are written over the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Reset returns the controller to idle, empties the output register and restores
// radius 2 and extent 64; tile memory contents are undefined until written.
// When the receiver stalls, the result waits in the output register and a query
// that finishes behind it holds until the register empties.
module deep_water_window_classifier #(
    parameter int GRID_SIDE  = 64,
    parameter int MAX_RADIUS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dwwc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dwwc_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import dwwc_pkg::*;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_EXTENT = 1'b1;

    logic [2:0]   radius_reg;
    logic [6:0]   extent_reg;
    logic         cfg_wr;
    dwwc_cmd_t    cmd;
    dwwc_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 3'd2;
            extent_reg <= 7'd64;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_RADIUS: radius_reg <= pwdata[2:0];
                REG_EXTENT: extent_reg <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RADIUS: prdata = {29'd0, radius_reg};
            REG_EXTENT: prdata = {25'd0, extent_reg};
            default:    prdata = '0;
        endcase
    end

    dwwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_kind  (s_data.kind),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dwwc_datapath #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_item     (s_data),
        .radius      (radius_reg),
        .grid_extent (extent_reg),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_ready),
        .out_valid   (m_valid),
        .out_item    (m_data)
    );

endmodule

// ===== dv/dwwc_tb_pkg.sv =====
// Constants shared by the classifier testbench and its checker: register
// addresses, register reset values and the spare class code.
// Depends on nothing.
package dwwc_tb_pkg;

    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam logic [2:0] ADDR_EXTENT = 3'd4;

    localparam int RADIUS_AT_RESET = 2;
    localparam int EXTENT_AT_RESET = 64;

    // The one class code that has no meaning; the block stores it as other.
    localparam logic [1:0] CLASS_SPARE = 2'd3;

endpackage

// ===== dv/dwwc_checker.sv =====
// Checker for the deep water window classifier: snoops the APB port and both
// channels, keeps its own tile grid and predicts every query result.
// Depends on dwwc_pkg and dwwc_tb_pkg.
module dwwc_checker #(
    parameter int GRID_SIDE  = 64,
    parameter int MAX_RADIUS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dwwc_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dwwc_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  err_count,
    output int                  pending,
    output int                  deep_count
);
    import dwwc_pkg::*;
    import dwwc_tb_pkg::*;

    logic [CLASS_W-1:0] tile_class_grid [GRID_SIDE*GRID_SIDE];
    logic               tile_ocean_grid [GRID_SIDE*GRID_SIDE];
    int                 cfg_radius;
    int                 cfg_extent;
    out_item_t          awaited_tiles [$];

    function automatic logic [CLASS_W-1:0] classify_tile(input int cx, input int cy);
        int                 r;
        int                 ext;
        int                 x;
        int                 y;
        int                 idx;
        logic               all_wet;
        logic [CLASS_W-1:0] cls;
        r   = (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
        ext = (cfg_extent > GRID_SIDE) ? GRID_SIDE : cfg_extent;
        idx = cy * GRID_SIDE + cx;
        cls = tile_class_grid[idx];
        if (cls == CLASS_WATER && tile_ocean_grid[idx]) begin
            all_wet = 1'b1;
            for (y = cy - r; y <= cy + r; y++) begin
                for (x = cx - r; x <= cx + r; x++) begin
                    // A window cell beyond the used extent counts as dry.
                    if (x < 0 || y < 0 || x >= ext || y >= ext) begin
                        all_wet = 1'b0;
                    end else if (tile_class_grid[y*GRID_SIDE+x] != CLASS_WATER &&
                                 tile_class_grid[y*GRID_SIDE+x] != CLASS_DEEP) begin
                        all_wet = 1'b0;
                    end
                end
            end
            if (all_wet) begin
                cls = CLASS_DEEP;
            end
        end
        return cls;
    endfunction

    always @(posedge aclk) begin : monitor
        int        bad;
        int        idx;
        out_item_t want;
        bad = 0;
        if (!aresetn) begin
            cfg_radius = RADIUS_AT_RESET;
            cfg_extent = EXTENT_AT_RESET;
            awaited_tiles.delete();
            err_count  <= 0;
            pending    <= 0;
            deep_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_RADIUS: cfg_radius = int'(pwdata[2:0]);
                    ADDR_EXTENT: cfg_extent = int'(pwdata[6:0]);
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (awaited_tiles.size() == 0) begin
                    $display("%0t: result (%0d,%0d) class %0d with no query outstanding",
                             $time, m_data.out_x, m_data.out_y, m_data.result_class);
                    bad++;
                end else begin
                    want = awaited_tiles.pop_front();
                    if (m_data.out_x !== want.out_x) begin
                        $display("%0t: out_x expected %0d, got %0d",
                                 $time, want.out_x, m_data.out_x);
                        bad++;
                    end
                    if (m_data.out_y !== want.out_y) begin
                        $display("%0t: out_y expected %0d, got %0d",
                                 $time, want.out_y, m_data.out_y);
                        bad++;
                    end
                    if (m_data.result_class !== want.result_class) begin
                        $display("%0t: tile (%0d,%0d) result_class expected %0d, got %0d",
                                 $time, want.out_x, want.out_y, want.result_class,
                                 m_data.result_class);
                        bad++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                idx = int'(s_data.pos_y) * GRID_SIDE + int'(s_data.pos_x);
                if (s_data.kind == KIND_WRITE) begin
                    if (s_data.tile_class == CLASS_WATER || s_data.tile_class == CLASS_DEEP) begin
                        tile_class_grid[idx] = s_data.tile_class;
                    end else begin
                        tile_class_grid[idx] = CLASS_OTHER;
                    end
                    tile_ocean_grid[idx] = s_data.in_ocean;
                end else begin
                    want.out_x        = s_data.pos_x;
                    want.out_y        = s_data.pos_y;
                    want.result_class = classify_tile(int'(s_data.pos_x), int'(s_data.pos_y));
                    awaited_tiles.push_back(want);
                    if (want.result_class == CLASS_DEEP) begin
                        deep_count <= deep_count + 1;
                    end
                end
            end

            err_count <= err_count + bad;
            pending   <= awaited_tiles.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the deep water window classifier: clock, reset, APB
// register writes, tile write and query stimulus, and the final verdict.
// Depends on dwwc_pkg, dwwc_tb_pkg, dwwc_checker and the block itself.
module tb;
    import dwwc_pkg::*;
    import dwwc_tb_pkg::*;

    localparam int GRID_SIDE        = 64;
    localparam int MAX_RADIUS       = 7;
    localparam int LAST             = GRID_SIDE - 1;
    localparam int EXTENT_FIELD_MAX = 127;
    localparam int RANDOM_ITEMS     = 650;
    localparam int MAX_GAP          = 5;
    localparam int SETTLE_CYCLES    = 240;
    localparam int TAIL_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef enum int {SEQ_DEEP, SEQ_MIXED, SEQ_SPOIL, SEQ_NOISE} seq_kind_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int err_count;
    int pending;
    int deep_count;

    // Stimulus bookkeeping: which tiles hold data, and which of them are wet.
    bit tile_written [GRID_SIDE*GRID_SIDE];
    bit tile_wet     [GRID_SIDE*GRID_SIDE];

    int cur_radius    = RADIUS_AT_RESET;
    int next_gap      = 1;
    bit quiet         = 1'b0;
    int sent          = 0;
    int writes_sent   = 0;
    int queries_sent  = 0;
    int settings_used = 0;
    int cycle_count   = 0;

    deep_water_window_classifier #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_RADIUS(MAX_RADIUS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    dwwc_checker #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .err_count (err_count),
        .pending   (pending),
        .deep_count(deep_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int grid_index(input int x, input int y);
        return y * GRID_SIDE + x;
    endfunction

    function automatic int clamp(input int v);
        return (v < 0) ? 0 : ((v > LAST) ? LAST : v);
    endfunction

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // A query may only be made once its whole window, clipped to the grid,
    // has been written.
    function automatic bit window_ready(input int cx, input int cy);
        int x;
        int y;
        for (y = clamp(cy - cur_radius); y <= clamp(cy + cur_radius); y++) begin
            for (x = clamp(cx - cur_radius); x <= clamp(cx + cur_radius); x++) begin
                if (!tile_written[grid_index(x, y)]) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Valid is lowered at the accepting edge only when a gap follows, so that a
    // back-to-back transaction keeps it high without a second assignment.
    task automatic drive_item(input in_item_t item);
        int idx;
        if (next_gap != 0) begin
            repeat (next_gap) @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (item.kind == KIND_WRITE) begin
            idx = grid_index(int'(item.pos_x), int'(item.pos_y));
            writes_sent++;
            tile_written[idx] = 1'b1;
            tile_wet[idx] = (item.tile_class == CLASS_WATER || item.tile_class == CLASS_DEEP);
        end else begin
            queries_sent++;
        end
        next_gap = draw_gap();
        if (next_gap != 0) begin
            s_valid <= 1'b0;
        end
    endtask

    task automatic write_tile(input int x, input int y, input logic [CLASS_W-1:0] cls,
                              input logic ocean);
        in_item_t item;
        item.kind       = KIND_WRITE;
        item.pos_x      = COORD_W'(x);
        item.pos_y      = COORD_W'(y);
        item.tile_class = cls;
        item.in_ocean   = ocean;
        drive_item(item);
    endtask

    task automatic query_tile(input int x, input int y);
        in_item_t item;
        item.kind       = KIND_QUERY;
        item.pos_x      = COORD_W'(x);
        item.pos_y      = COORD_W'(y);
        item.tile_class = CLASS_W'($urandom_range(0, 3));
        item.in_ocean   = 1'($urandom_range(0, 1));
        drive_item(item);
    endtask

    task automatic apb_write(input logic [2:0] addr, input int value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop the sender, wait for every outstanding result, then let a full
    // query time pass so that a trailing tile write has certainly landed.
    task automatic drain();
        if (next_gap == 0) begin
            s_valid  <= 1'b0;
            next_gap = 1;
        end
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input int r, input int ext);
        drain();
        apb_write(ADDR_RADIUS, r);
        apb_write(ADDR_EXTENT, ext);
        cur_radius = r;
        settings_used++;
    endtask

    task automatic random_wet_write(input int x, input int y);
        write_tile(x, y, ($urandom_range(0, 1) != 0) ? CLASS_WATER : CLASS_DEEP,
                   1'($urandom_range(0, 1)));
    endtask

    task automatic random_dry_write(input int x, input int y);
        write_tile(x, y, ($urandom_range(0, 1) != 0) ? CLASS_OTHER : CLASS_SPARE,
                   1'($urandom_range(0, 1)));
    endtask

    // Fills the window per kind, then queries its centre; noise may skip both.
    task automatic window_sequence(input int cx, input int cy, input seq_kind_t kind);
        int x;
        int y;
        int x0;
        int x1;
        int y0;
        int y1;
        int idx;
        int wet_pct;
        x0 = clamp(cx - cur_radius);
        x1 = clamp(cx + cur_radius);
        y0 = clamp(cy - cur_radius);
        y1 = clamp(cy + cur_radius);
        wet_pct = ($urandom_range(0, 2) == 0) ? 80 : 100;
        if (kind == SEQ_NOISE) begin
            repeat ($urandom_range(1, 4)) begin
                write_tile($urandom_range(0, LAST), $urandom_range(0, LAST),
                           CLASS_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
            if (window_ready(cx, cy)) begin
                query_tile(cx, cy);
            end
            return;
        end
        for (y = y0; y <= y1; y++) begin
            for (x = x0; x <= x1; x++) begin
                idx = grid_index(x, y);
                if (kind == SEQ_DEEP && (!tile_written[idx] || !tile_wet[idx])) begin
                    random_wet_write(x, y);
                end else if (!tile_written[idx]) begin
                    if ($urandom_range(1, 100) <= wet_pct) begin
                        random_wet_write(x, y);
                    end else begin
                        random_dry_write(x, y);
                    end
                end
            end
        end
        case (kind)
            SEQ_DEEP: write_tile(cx, cy, CLASS_WATER, 1'b1);
            SEQ_SPOIL: begin
                if ($urandom_range(0, 1) != 0) begin
                    write_tile(cx, cy, CLASS_WATER, 1'b0);
                end else begin
                    random_dry_write($urandom_range(x0, x1), $urandom_range(y0, y1));
                end
            end
            default: begin
                if ($urandom_range(0, 1) != 0) begin
                    write_tile(cx, cy, CLASS_WATER, 1'b1);
                end
            end
        endcase
        query_tile(cx, cy);
    endtask

    // The receiver either stalls ahead of a result or holds one back once shown.
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 1) != 0) begin
                    @(posedge aclk);
                    while (!m_valid) @(posedge aclk);
                end
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending);
        $display("** deep_water_window_classifier: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int        directed_items;
        int        r;
        int        ext;
        int        ax;
        int        ay;
        int        cx;
        int        cy;
        int        home_x;
        int        home_y;
        int        pick;
        seq_kind_t kind;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: corners, every class code, the extent edge cases.
        set_registers(0, GRID_SIDE);
        write_tile(0, 0, CLASS_WATER, 1'b1);
        query_tile(0, 0);
        write_tile(LAST, LAST, CLASS_WATER, 1'b1);
        query_tile(LAST, LAST);
        write_tile(LAST, 0, CLASS_SPARE, 1'b1);
        query_tile(LAST, 0);
        write_tile(0, LAST, CLASS_DEEP, 1'b0);
        query_tile(0, LAST);
        write_tile(1, 0, CLASS_WATER, 1'b0);
        query_tile(1, 0);
        set_registers(0, GRID_SIDE - 1);
        query_tile(LAST, LAST);
        query_tile(0, 0);
        set_registers(0, 1);
        query_tile(0, 0);
        query_tile(1, 0);
        set_registers(0, 0);
        query_tile(0, 0);
        set_registers(0, EXTENT_FIELD_MAX);
        query_tile(LAST, LAST);
        set_registers(1, GRID_SIDE);
        write_tile(0, 1, CLASS_WATER, 1'b1);
        write_tile(1, 1, CLASS_DEEP, 1'b1);
        query_tile(0, 0);
        write_tile(LAST, LAST, CLASS_OTHER, 1'b1);
        query_tile(LAST, LAST);
        directed_items = sent;

        // Most phases work around one home area, so that large windows there
        // are cheap to prepare once the area has been written.
        home_x = $urandom_range(8, GRID_SIDE - 9);
        home_y = $urandom_range(8, GRID_SIDE - 9);
        while (sent < directed_items + RANDOM_ITEMS) begin
            r = ($urandom_range(0, 99) < 15) ? $urandom_range(4, MAX_RADIUS)
                                             : $urandom_range(0, 3);
            case ($urandom_range(0, 7))
                0:       ext = GRID_SIDE;
                1:       ext = 1;
                2:       ext = $urandom_range(1, GRID_SIDE);
                default: ext = $urandom_range(48, GRID_SIDE);
            endcase
            set_registers(r, ext);
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                ax = home_x;
                ay = home_y;
            end else begin
                ax = ($urandom_range(0, 1) != 0) ? $urandom_range(0, LAST)
                                                 : (($urandom_range(0, 1) != 0) ? 0 : LAST);
                ay = ($urandom_range(0, 1) != 0) ? $urandom_range(0, LAST)
                                                 : (($urandom_range(0, 1) != 0) ? 0 : LAST);
            end
            repeat ((r >= 4) ? $urandom_range(2, 4) : $urandom_range(4, 10)) begin
                cx   = clamp(ax + int'($urandom_range(0, 8)) - 4);
                cy   = clamp(ay + int'($urandom_range(0, 8)) - 4);
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    kind = SEQ_DEEP;
                end else if (pick < 75) begin
                    kind = SEQ_MIXED;
                end else if (pick < 90) begin
                    kind = SEQ_SPOIL;
                end else begin
                    kind = SEQ_NOISE;
                end
                if (sent < directed_items + RANDOM_ITEMS) begin
                    window_sequence(cx, cy, kind);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES - SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d tile writes and %0d queries, %0d of them deepwater,",
                 writes_sent, queries_sent, deep_count);
        $display("over %0d settings of radius and extent.", settings_used);
        if (err_count == 0 && pending == 0) begin
            $display("** deep_water_window_classifier: PASSED **");
        end else begin
            $display("** deep_water_window_classifier: FAILED **");
        end
        $finish;
    end

endmodule
